// ----- design/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// chd_pkg
// Shared constants and types for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  // Default width of the chunk size counters
  localparam int unsigned SizeBitsDef = 31;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  // One result request from the parser to the output stage
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  // Hex digit decode: valid flag and 4-bit value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- design/chd_parse.sv -----
// ----------------------------------------------------------------------------
// chd_parse
// Per-byte parser: size line, data pass-through and trailing CRLF drop.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_parse #(
  parameter int unsigned SizeBits = chd_pkg::SizeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output chd_pkg::res_t    res_o
);

  // Phase codes
  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_CR_SIZE = 3'd2;
  localparam logic [2:0] PH_CR_EXT  = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_DROP1   = 3'd5;
  localparam logic [2:0] PH_DROP2   = 3'd6;

  logic [2:0]          phase_q, phase_d;
  logic [SizeBits-1:0] accum_q, accum_d;
  logic [SizeBits-1:0] left_q, left_d;
  logic                digit_q, digit_d;
  logic                bad_q, bad_d;
  logic                space_q, space_d;
  chd_pkg::hex_t       hex;
  logic                is_cr, is_lf;

  assign hex   = chd_pkg::hex_decode(byte_i);
  assign is_cr = (byte_i == chd_pkg::CH_CR);
  assign is_lf = (byte_i == chd_pkg::CH_LF);

  // Next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    left_d     = left_q;
    digit_d    = digit_q;
    bad_d      = bad_q;
    space_d    = space_q;
    res_o      = '0;

    unique case (phase_q)
      PH_EXT: begin
        if (is_cr) phase_d = PH_CR_EXT;
      end
      PH_CR_SIZE, PH_CR_EXT: begin
        if (is_lf) begin
          // LF closes the size line
          if (bad_q || !digit_q || accum_q == '0) begin
            phase_d    = PH_SIZE;
            accum_d    = '0;
            digit_d    = 1'b0;
            bad_d      = 1'b0;
            space_d    = 1'b0;
            res_o.valid = 1'b1;
            res_o.kind  = (bad_q || !digit_q) ? chd_pkg::KIND_BAD : chd_pkg::KIND_END;
          end else begin
            left_d  = accum_q;
            accum_d = '0;
            phase_d = PH_DATA;
          end
        end else begin
          if (phase_q == PH_CR_SIZE) bad_d = 1'b1;
          if (!is_cr) phase_d = PH_EXT;
        end
      end
      PH_DATA: begin
        res_o.valid = 1'b1;
        res_o.kind  = chd_pkg::KIND_DATA;
        res_o.data  = byte_i;
        if (left_q != '0) left_d = left_q - 1'b1;
        if (left_d == '0) phase_d = PH_DROP1;
      end
      PH_DROP1: begin
        phase_d = PH_DROP2;
      end
      PH_DROP2: begin
        phase_d = PH_SIZE;
        accum_d = '0;
        digit_d = 1'b0;
        bad_d   = 1'b0;
        space_d = 1'b0;
      end
      default: begin
        // Size part (and the unused code)
        phase_d = PH_SIZE;
        if (hex.ok) begin
          if (space_q || accum_q[SizeBits-1 -: 4] != 4'd0) begin
            bad_d = 1'b1;
          end else begin
            accum_d = {accum_q[SizeBits-5:0], hex.val};
            digit_d = 1'b1;
          end
        end else if (byte_i == chd_pkg::CH_SP || byte_i == chd_pkg::CH_TAB) begin
          if (digit_q) space_d = 1'b1;
        end else if (byte_i == chd_pkg::CH_SEMI) begin
          phase_d = PH_EXT;
        end else if (is_cr) begin
          phase_d = PH_CR_SIZE;
        end else begin
          bad_d = 1'b1;
        end
      end
    endcase
  end

  // State registers, advanced once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      accum_q <= '0;
      left_q  <= '0;
      digit_q <= 1'b0;
      bad_q   <= 1'b0;
      space_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      digit_q <= digit_d;
      bad_q   <= bad_d;
      space_q <= space_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/chd_outbuf.sv -----
// ----------------------------------------------------------------------------
// chd_outbuf
// Result register with valid/stall handshake toward the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_outbuf (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  chd_pkg::res_t   res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;

  // Free when empty or being taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      kind_q <= res_i.kind;
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = data_q;

endmodule

`default_nettype wire

// ----- design/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body one byte per request into data, end and
// error results.
// ----------------------------------------------------------------------------
//  Channel | Ports                               | Direction
//  --------+-------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_byte_i   | sink
//  out     | out_valid_o, out_stall_i,           | source
//          | out_kind_o, out_byte_o              |
//
//  One byte per cycle sustained while the sink does not stall; a result is
//  valid from the result register after its byte has passed the input register.
//  Size line parsing and data counting update in the same cycle a byte
//  leaves the input register.
//  Reset is asynchronous, active low, and returns to waiting for a size line.
//  in_stall_o rises only while both the input and result registers are full
//  and the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SizeBits = chd_pkg::SizeBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o
);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          step;
  logic          out_free;
  chd_pkg::res_t res;

  // Byte leaves the input register when the result register can take it
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= in_byte_i;
  end

  chd_parse #(
    .SizeBits (SizeBits)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  chd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o)
  );

endmodule

`default_nettype wire

// ----- design/chd_checker.sv -----
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] out_kind_o,
  input wire logic [7:0] out_byte_o
);

  // Only the three defined kinds leave the block
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == chd_pkg::KIND_DATA ||
                     out_kind_o == chd_pkg::KIND_END ||
                     out_kind_o == chd_pkg::KIND_BAD))
    else $error("undefined result kind");

  // End and error results carry a zero byte
  a_ctrl_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o != chd_pkg::KIND_DATA) |-> out_byte_o == 8'd0)
    else $error("non-data result with nonzero byte");

  // Input back-pressure only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // Stalled request holds on the input side
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_byte_i)))
    else $error("stalled request changed");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_kind_o) && $stable(out_byte_o)))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_byte_i   (in_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_kind_o  (out_kind_o),
  .out_byte_o  (out_byte_o)
);

`default_nettype wire
